[rtl/mf12_pkg.sv]
// mf12_pkg: shared types and constants for the 12-bit minifloat add/multiply unit.
// Holds the transaction structs and status codes; no dependencies.
package mf12_pkg;

  localparam int unsigned WordW = 12;
  localparam int unsigned ExpW  = 5;
  localparam int unsigned FracW = 7;
  localparam int unsigned SigW  = FracW + 1;

  localparam logic [ExpW-1:0]  ExpBias  = 5'd15;
  localparam logic [ExpW-1:0]  ExpMax   = 5'd31;
  localparam logic [WordW-1:0] WordOnes = 12'hfff;

  // status codes of a result
  localparam logic [1:0] StNormal    = 2'd0;
  localparam logic [1:0] StOverflow  = 2'd1;
  localparam logic [1:0] StUnderflow = 2'd2;

  // operation select
  localparam logic OpAdd = 1'b0;
  localparam logic OpMul = 1'b1;

  typedef struct packed {
    logic             op;
    logic [WordW-1:0] a_word;
    logic [WordW-1:0] b_word;
  } mf12_in_t;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic [1:0]       status;
  } mf12_out_t;

endpackage

[rtl/minifloat12_add_mul_unit.sv]
// minifloat12_add_mul_unit: top level of the 12-bit minifloat add/multiply unit.
// Depends on mf12_pkg and mf12_datapath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  input    | start / busy       | in_item  (op, a_word, b_word)
//  result   | out_valid (strobe) | out_item (result_word, status)
//
// One transaction per cycle; busy is never raised.
// Operands go into the operand register, then one pass of add or 8x8 multiply,
// normalize and range check feeds the result register.
// Synchronous active-low reset clears both valid flags; payload registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module minifloat12_add_mul_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mf12_pkg::mf12_in_t  in_item,
  output logic                out_valid,
  output mf12_pkg::mf12_out_t out_item
);
  import mf12_pkg::*;

  logic      in_valid_r, in_valid_nxt;
  mf12_in_t  in_item_r;
  logic      out_valid_r, out_valid_nxt;
  mf12_out_t out_item_r;
  mf12_out_t dp_out;

  assign busy          = 1'b0;
  assign in_valid_nxt  = start && !busy;
  assign out_valid_nxt = in_valid_r;

  mf12_datapath u_dp (
    .in_d  (in_item_r),
    .out_d (dp_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_nxt) begin
      in_item_r <= in_item;
    end
    if (in_valid_r) begin
      out_item_r <= dp_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // every accepted transaction yields a result through the operand and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted transaction produced no result");

  a_ovf_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == StOverflow) |-> (out_item.result_word == WordOnes))
    else $error("overflow result is not all ones");

  a_unf_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == StUnderflow) |-> (out_item.result_word == '0))
    else $error("underflow result is not zero");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == StNormal || out_item.status == StOverflow ||
                   out_item.status == StUnderflow))
    else $error("undefined status code");

  a_normal_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == StNormal) |->
      (out_item.result_word[WordW-1:FracW] != '0 &&
       out_item.result_word[WordW-1:FracW] != ExpMax))
    else $error("normal result with out-of-range exponent");

endmodule

[rtl/mf12_datapath.sv]
// mf12_datapath: combinational add/multiply, normalize and range check for one operand pair.
// Depends on mf12_pkg.
module mf12_datapath (
  input  mf12_pkg::mf12_in_t  in_d,
  output mf12_pkg::mf12_out_t out_d
);
  import mf12_pkg::*;

  logic [ExpW-1:0]    ea, eb, ebig, esmall, ediff;
  logic [SigW-1:0]    ma, mb, mbig, msmall, mshift;
  logic [2*SigW-1:0]  prod;
  logic [SigW:0]      mul_sig, add_sig, sig, sig_norm;
  logic               b_bigger;
  // signed exponent, covers -15..48
  logic signed [6:0]  mul_exp, exp_pre, exp_fin;

  always_comb begin
    ea = in_d.a_word[WordW-1:FracW];
    eb = in_d.b_word[WordW-1:FracW];
    ma = {1'b1, in_d.a_word[FracW-1:0]};
    mb = {1'b1, in_d.b_word[FracW-1:0]};

    // multiply path
    prod    = (2*SigW)'(ma) * (2*SigW)'(mb);
    mul_sig = prod[2*SigW-1:FracW];
    mul_exp = signed'({2'b00, ea}) + signed'({2'b00, eb}) - signed'({2'b00, ExpBias});

    // add path: larger word is the larger value
    b_bigger = (in_d.b_word > in_d.a_word);
    ebig     = b_bigger ? eb : ea;
    esmall   = b_bigger ? ea : eb;
    mbig     = b_bigger ? mb : ma;
    msmall   = b_bigger ? ma : mb;
    ediff    = ebig - esmall;
    mshift   = (ediff >= ExpW'(SigW)) ? '0 : (msmall >> ediff);
    add_sig  = {1'b0, mbig} + {1'b0, mshift};

    if (in_d.op == OpMul) begin
      sig     = mul_sig;
      exp_pre = mul_exp;
    end else begin
      sig     = add_sig;
      exp_pre = signed'({2'b00, ebig});
    end

    // one right shift is always enough
    if (sig[SigW]) begin
      sig_norm = sig >> 1;
      exp_fin  = exp_pre + 7'sd1;
    end else begin
      sig_norm = sig;
      exp_fin  = exp_pre;
    end

    if (exp_fin >= signed'({2'b00, ExpMax})) begin
      out_d.result_word = WordOnes;
      out_d.status      = StOverflow;
    end else if (exp_fin < 7'sd1) begin
      out_d.result_word = '0;
      out_d.status      = StUnderflow;
    end else begin
      out_d.result_word = {exp_fin[ExpW-1:0], sig_norm[FracW-1:0]};
      out_d.status      = StNormal;
    end
  end

endmodule

[tb/sv/tb_top.sv]
// tb_top: self-checking bench for minifloat12_add_mul_unit (add and multiply of 12-bit minifloats).
// A queue-fed driver and a strobe monitor check each result against a local predictor.
// Depends on mf12_pkg and the RTL top level only.
module tb_top;
  import mf12_pkg::*;

  localparam int StallLimit = 1000;

  typedef struct {
    mf12_in_t item;
    bit       may_idle;
    bit       wait_drain;
  } op_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  mf12_in_t  in_item = '0;
  logic      out_valid;
  mf12_out_t out_item;

  op_req_t   ops_pending[$];
  mf12_out_t results_expected[$];
  int        ops_sent = 0;
  int        results_seen = 0;
  int        errors = 0;
  int        stall_cycles = 0;

  minifloat12_add_mul_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  // Expected result of one operation: truncating significand math, a single
  // normalize step, then the exponent range check.
  function automatic mf12_out_t minifloat_result(mf12_in_t x);
    logic [WordW-1:0] hi_word, lo_word;
    logic [SigW-1:0]  sig_hi, sig_lo, sig_a, sig_b;
    logic [2*SigW-1:0] prod;
    logic [SigW:0]    sig;
    int               res_exp, diff;
    mf12_out_t        r;
    sig_a = {1'b1, x.a_word[FracW-1:0]};
    sig_b = {1'b1, x.b_word[FracW-1:0]};
    if (x.op == OpMul) begin
      prod = (2*SigW)'(sig_a) * (2*SigW)'(sig_b);
      sig = prod[2*SigW-1:FracW];
      res_exp = int'(x.a_word[WordW-1:FracW]) + int'(x.b_word[WordW-1:FracW]) - int'(ExpBias);
    end else begin
      hi_word = x.a_word;
      lo_word = x.b_word;
      if (x.b_word > x.a_word) begin
        hi_word = x.b_word;
        lo_word = x.a_word;
      end
      sig_hi = {1'b1, hi_word[FracW-1:0]};
      sig_lo = {1'b1, lo_word[FracW-1:0]};
      diff = int'(hi_word[WordW-1:FracW]) - int'(lo_word[WordW-1:FracW]);
      if (diff >= int'(SigW)) sig_lo = '0;
      else sig_lo = sig_lo >> diff;
      sig = {1'b0, sig_hi} + {1'b0, sig_lo};
      res_exp = int'(hi_word[WordW-1:FracW]);
    end
    if (sig[SigW]) begin
      sig = sig >> 1;
      res_exp = res_exp + 1;
    end
    if (res_exp >= int'(ExpMax)) begin
      r.result_word = WordOnes;
      r.status = StOverflow;
    end else if (res_exp < 1) begin
      r.result_word = '0;
      r.status = StUnderflow;
    end else begin
      r.result_word = {res_exp[ExpW-1:0], sig[FracW-1:0]};
      r.status = StNormal;
    end
    return r;
  endfunction

  task automatic queue_op(logic op, logic [WordW-1:0] a, logic [WordW-1:0] b,
                          bit may_idle, bit wait_drain);
    op_req_t req;
    req.item.op = op;
    req.item.a_word = a;
    req.item.b_word = b;
    req.may_idle = may_idle;
    req.wait_drain = wait_drain;
    ops_pending.push_back(req);
  endtask

  function automatic logic [ExpW-1:0] clamp_exp(int e);
    if (e < 0) return '0;
    if (e > int'(ExpMax)) return ExpMax;
    return e[ExpW-1:0];
  endfunction

  // Driver: records each accepted transaction, then presents the next one.
  always @(posedge clk) begin
    op_req_t req;
    bit      took;
    bit      hold_off;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        results_expected.push_back(minifloat_result(in_item));
        ops_sent++;
      end
      if (took || !start) begin
        if (ops_pending.size() == 0) begin
          start <= 1'b0;
        end else begin
          // results_seen is updated nonblocking, so this may lag the monitor by one update at most
          hold_off = ops_pending[0].wait_drain && (ops_sent != results_seen);
          if (hold_off || (ops_pending[0].may_idle && $urandom_range(99) < 20)) begin
            start <= 1'b0;
          end else begin
            req = ops_pending.pop_front();
            in_item <= req.item;
            start <= 1'b1;
          end
        end
      end
    end
  end

  // Monitor: the strobe cannot be held off, so every strobed cycle is checked.
  always @(posedge clk) begin
    mf12_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      results_seen <= results_seen + 1;
      if (results_expected.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual word %h status %0d",
                 $time, out_item.result_word, out_item.status);
        errors++;
      end else begin
        want = results_expected.pop_front();
        if (out_item.result_word !== want.result_word) begin
          $display("%0t: result_word mismatch: expected %h, actual %h",
                   $time, want.result_word, out_item.result_word);
          errors++;
        end
        if (out_item.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_item.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid === 1'b1) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int               n;
    int               ea, eb;
    logic             op;
    logic [WordW-1:0] a, b;
    bit               drain;

    // multiply corners
    queue_op(OpMul, 12'h000, 12'h000, 1, 0);  // exponent sum far below range
    queue_op(OpMul, 12'hfff, 12'hfff, 1, 0);  // far above range
    queue_op(OpMul, 12'h780, 12'h780, 1, 0);  // one times one
    queue_op(OpMul, 12'h7ff, 12'h7ff, 1, 0);  // product needs renormalizing
    queue_op(OpMul, 12'h400, 12'h380, 1, 0);  // lands on exponent zero
    queue_op(OpMul, 12'h400, 12'h400, 1, 0);  // smallest normal result
    queue_op(OpMul, 12'hb80, 12'hb80, 1, 0);  // lands on exponent 31
    queue_op(OpMul, 12'hb80, 12'hb00, 1, 0);  // largest normal exponent
    queue_op(OpMul, 12'hbff, 12'hb7f, 1, 0);  // renormalize pushes into overflow
    queue_op(OpMul, 12'hf80, 12'h000, 1, 0);
    queue_op(OpMul, 12'h07f, 12'hfff, 1, 0);
    // add corners
    queue_op(OpAdd, 12'h000, 12'h000, 1, 0);
    queue_op(OpAdd, 12'hfff, 12'hfff, 1, 0);
    queue_op(OpAdd, 12'hf7f, 12'hf00, 1, 0);  // carry pushes into overflow
    queue_op(OpAdd, 12'h780, 12'h780, 1, 0);  // equal words
    queue_op(OpAdd, 12'hf80, 12'h000, 1, 0);  // huge exponent gap
    queue_op(OpAdd, 12'h400, 12'h000, 1, 0);  // gap of 8 drops the smaller
    queue_op(OpAdd, 12'h400, 12'h080, 1, 0);  // gap of 7 keeps one bit
    queue_op(OpAdd, 12'h123, 12'h456, 1, 0);  // second operand larger
    queue_op(OpAdd, 12'hcff, 12'h000, 1, 0);
    queue_op(OpAdd, 12'h7ab, 12'h7cd, 1, 0);
    queue_op(OpAdd, 12'h000, 12'h07f, 1, 0);

    for (n = 0; n < 650; n++) begin
      op = $urandom_range(1) ? OpMul : OpAdd;
      a = 12'($urandom_range(4095));
      b = 12'($urandom_range(4095));
      case ($urandom_range(9)) inside
        [0:3]: ;
        [4:6]: begin
          // steer exponents so the result sits near either range limit
          op = OpMul;
          ea = int'(a[WordW-1:FracW]);
          if ($urandom_range(1)) eb = 15 + $urandom_range(29, 32) - ea;
          else eb = 15 + $urandom_range(0, 2) - ea;
          b[WordW-1:FracW] = clamp_exp(eb);
        end
        default: begin
          // close exponents exercise the alignment shifter
          op = OpAdd;
          ea = int'(a[WordW-1:FracW]);
          b[WordW-1:FracW] = clamp_exp(ea + $urandom_range(0, 18) - 9);
        end
      endcase
      drain = (n == 0) || (n == 320) || (n == 500);
      queue_op(op, a, b, !(n >= 250 && n < 400), drain);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (ops_pending.size() != 0 || start || results_expected.size() != 0);
    repeat (8) @(posedge clk);

    if (results_expected.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, results_expected.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mf12_pkg.sv
rtl/mf12_datapath.sv
rtl/minifloat12_add_mul_unit.sv
tb/sv/tb_top.sv
